>>> rtl/crv_pkg.sv
// shared constants, tables, types and helpers of the comb/allpass reverb
package crv_pkg;

   localparam int BANK_BITS = 11;
   localparam int MAX_COMBS = 16;
   localparam int MAX_ALLPASS = 8;
   localparam int DEF_COMBS = 8;
   localparam int DEF_ALLPASS = 4;
   localparam int DEF_STATE_WIDTH = 24;

   localparam logic [1:0] REG_ROOM_SIZE = 2'd0;
   localparam logic [1:0] REG_DAMPING   = 2'd1;
   localparam logic [1:0] REG_WET_LEVEL = 2'd2;

   localparam logic [15:0] ROOM_RESET = 16'd32768;
   localparam logic [15:0] DAMP_RESET = 16'd32768;
   localparam logic [15:0] WET_RESET  = 16'd19661;

   // feedback = 0.7 + 0.28 * room size, Q0.16
   localparam logic [15:0] FB_BASE = 16'd45875;
   localparam logic [14:0] FB_SPAN = 15'd18350;

   localparam logic [10:0] COMB_LEN_L [MAX_COMBS] = '{
      11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617,
      11'd1671, 11'd1723, 11'd1777, 11'd1831, 11'd1879, 11'd1913, 11'd1979, 11'd2011};
   localparam logic [10:0] COMB_LEN_R [MAX_COMBS] = '{
      11'd1139, 11'd1211, 11'd1300, 11'd1379, 11'd1445, 11'd1514, 11'd1580, 11'd1640,
      11'd1694, 11'd1746, 11'd1800, 11'd1854, 11'd1902, 11'd1936, 11'd2002, 11'd2034};
   localparam logic [10:0] AP_LEN_L [MAX_ALLPASS] = '{
      11'd556, 11'd441, 11'd341, 11'd225, 11'd605, 11'd653, 11'd701, 11'd751};
   localparam logic [10:0] AP_LEN_R [MAX_ALLPASS] = '{
      11'd579, 11'd464, 11'd364, 11'd248, 11'd628, 11'd676, 11'd724, 11'd774};

   typedef struct packed {
      logic idle;
      logic load;
   } crv_status_type;

   function automatic logic [10:0] comb_len(input logic side, input int k);
      if (side) begin
         return COMB_LEN_R[k];
      end
      return COMB_LEN_L[k];
   endfunction

   function automatic logic [10:0] ap_len(input logic side, input int k);
      if (side) begin
         return AP_LEN_R[k];
      end
      return AP_LEN_L[k];
   endfunction

endpackage

>>> rtl/comb_allpass_reverb_core.sv
// top level of the comb/allpass stereo reverb: registers, handshakes, output stage
//
// One request carries a stereo frame (req_left_in, req_right_in, req_block_end_in);
// one response carries the mixed frame (rsp_left_out, rsp_right_out,
// rsp_block_end_out). A request is taken when req_valid is high and req_stall low,
// a response is taken when rsp_valid is high and rsp_stall low.
// Registers are written through csr_valid/csr_ready with csr_index 0 room size,
// 1 damping, 2 wet level; other indexes are ignored. csr_ready is always high.
// After reset the delay memory is zeroed one entry a cycle, and req_stall stays
// high during that pass.
// All delay lines share one memory port, so frames are processed one at a time:
// each comb steps through S_RD, S_CM1, S_CM2 and S_CWR and each allpass through
// S_RD and S_AP; S_MIX1, S_MIX2 and S_DONE then finish the frame.
// rsp_valid rises when S_DONE loads the mixed frame into the output register.
// A finished frame sits in the output register; the next request is accepted
// meanwhile, and if the receiver still stalls when that frame is done,
// the engine holds it until the output register frees up.
module comb_allpass_reverb_core #(
   parameter int COMBS_PER_SIDE = crv_pkg::DEF_COMBS,
   parameter int ALLPASS_PER_SIDE = crv_pkg::DEF_ALLPASS,
   parameter int STATE_WIDTH = crv_pkg::DEF_STATE_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_left_in,
   input  logic signed [15:0]  req_right_in,
   input  logic                req_block_end_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_left_out,
   output logic signed [15:0]  rsp_right_out,
   output logic                rsp_block_end_out,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data
);
   import crv_pkg::*;

   logic [15:0]          room_ff, damp_ff, wet_ff;
   logic                 rsp_valid_ff;
   logic signed [15:0]   rsp_left_ff, rsp_right_ff;
   logic                 rsp_be_ff;
   logic                 out_free;
   logic                 start;
   crv_status_type       status;
   logic signed [15:0]   eng_left, eng_right;
   logic                 eng_be;

   assign csr_ready = 1'b1;
   assign req_stall = !status.idle;
   assign start = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         room_ff <= ROOM_RESET;
         damp_ff <= DAMP_RESET;
         wet_ff <= WET_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ROOM_SIZE: room_ff <= csr_data;
            REG_DAMPING:   damp_ff <= csr_data;
            REG_WET_LEVEL: wet_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   crv_engine #(
      .COMBS_PER_SIDE(COMBS_PER_SIDE),
      .ALLPASS_PER_SIDE(ALLPASS_PER_SIDE),
      .STATE_WIDTH(STATE_WIDTH)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .start(start),
      .left_in(req_left_in),
      .right_in(req_right_in),
      .block_end_in(req_block_end_in),
      .room_level(room_ff),
      .damping(damp_ff),
      .wet_level(wet_ff),
      .out_free(out_free),
      .status(status),
      .left_out(eng_left),
      .right_out(eng_right),
      .block_end_out(eng_be)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (status.load) begin
         rsp_left_ff <= eng_left;
         rsp_right_ff <= eng_right;
         rsp_be_ff <= eng_be;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_out = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;
   assign rsp_block_end_out = rsp_be_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      status.load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over an untaken response");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall)
      else $error("engine idle right after taking a request");

   a_no_load_and_accept: assert property (@(posedge clock) disable iff (reset)
      !(status.load && start))
      else $error("request taken while a result is being loaded");

endmodule

>>> rtl/crv_engine.sv
// sequencer and datapath around the shared delay-line memory
module crv_engine #(
   parameter int COMBS_PER_SIDE = crv_pkg::DEF_COMBS,
   parameter int ALLPASS_PER_SIDE = crv_pkg::DEF_ALLPASS,
   parameter int STATE_WIDTH = crv_pkg::DEF_STATE_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [15:0]          left_in,
   input  logic signed [15:0]          right_in,
   input  logic                        block_end_in,
   input  logic [15:0]                 room_level,
   input  logic [15:0]                 damping,
   input  logic [15:0]                 wet_level,
   input  logic                        out_free,
   output crv_pkg::crv_status_type     status,
   output logic signed [15:0]          left_out,
   output logic signed [15:0]          right_out,
   output logic                        block_end_out
);
   import crv_pkg::*;

   localparam int SW = STATE_WIDTH;
   localparam int F = SW - 4;
   localparam int C = COMBS_PER_SIDE;
   localparam int A = ALLPASS_PER_SIDE;
   localparam int LINES = 2 * (C + A);
   localparam int LW = $clog2(LINES);
   localparam int AW = LW + BANK_BITS;
   localparam int DEPTH = LINES * (2 ** BANK_BITS);
   localparam int LPN = 2 * C;
   localparam int LPW = (LPN > 1) ? $clog2(LPN) : 1;
   localparam int MAXK = (C > A) ? C : A;
   localparam int KW = $clog2(MAXK + 1);
   localparam int XW = SW + 8;
   localparam int AC = SW + 34;
   localparam int MW = SW + 17;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_CM1  = 4'd3;
   localparam logic [3:0] S_CM2  = 4'd4;
   localparam logic [3:0] S_CWR  = 4'd5;
   localparam logic [3:0] S_AP   = 4'd6;
   localparam logic [3:0] S_MIX1 = 4'd7;
   localparam logic [3:0] S_MIX2 = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   function automatic logic signed [SW-1:0] sat_sw(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] hi;
      logic signed [XW-1:0] lo;
      hi = XW'((64'sd1 <<< (SW - 1)) - 64'sd1);
      lo = -hi - XW'(1);
      if (v > hi) begin
         return hi[SW-1:0];
      end
      if (v < lo) begin
         return lo[SW-1:0];
      end
      return v[SW-1:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [AC-1:0] v);
      if (v > AC'(32767)) begin
         return 16'sh7fff;
      end
      if (v < -AC'(32768)) begin
         return -16'sh8000;
      end
      return v[15:0];
   endfunction

   logic [3:0]               state_ff, state_in;
   logic [AW-1:0]            clr_ff;
   logic                     side_ff;
   logic                     in_ap_ff;
   logic [KW-1:0]            k_ff;
   logic [10:0]              pos_ff [LINES];
   logic signed [SW-1:0]     lp_ff [LPN];
   logic signed [SW-1:0]     mem [DEPTH];
   logic signed [SW-1:0]     rd_ff;
   logic signed [SW-1:0]     mono_ff;
   logic [15:0]              fb_ff;
   logic signed [SW+4:0]     sum_ff;
   logic signed [SW-1:0]     x_ff;
   logic signed [SW-1:0]     rev0_ff;
   logic signed [SW-1:0]     rev1_ff;
   logic signed [SW+17:0]    m1_ff;
   logic signed [SW+17:0]    m2_ff;
   logic signed [SW+16:0]    m3_ff;
   logic signed [15:0]       l_ff, r_ff;
   logic                     be_ff;
   logic signed [33:0]       pl_ff, pr_ff;
   logic signed [SW+16:0]    ql_ff, qr_ff;
   logic signed [15:0]       lo_ff, ro_ff;

   logic [LW-1:0]            line_idx;
   logic [LPW-1:0]           lp_idx;
   logic [10:0]              pos_cur;
   logic [10:0]              len_cur;
   logic [11:0]              pos_inc;
   logic [10:0]              pos_nxt;
   logic                     last_k;
   logic [AW-1:0]            addr;
   logic                     we;
   logic [AW-1:0]            waddr;
   logic signed [SW-1:0]     wdata;
   logic [16:0]              dcomp;
   logic [16:0]              dry;
   logic signed [SW+18:0]    lp_sum;
   logic signed [SW-1:0]     lp_new;
   logic signed [SW-1:0]     comb_wv;
   logic signed [SW-1:0]     ap_y;
   logic signed [SW-1:0]     ap_wv;
   logic signed [SW-1:0]     x_from_sum;
   logic [30:0]              fb_prod;
   logic signed [16:0]       in_sum;
   logic signed [MW-1:0]     mono_w;
   logic signed [AC-1:0]     acc_l, acc_r;

   always_comb begin
      line_idx = LW'(int'(side_ff) * (C + A) + (in_ap_ff ? C : 0) + int'(k_ff));
      lp_idx = LPW'(int'(side_ff) * C + int'(k_ff));
      pos_cur = pos_ff[line_idx];
      len_cur = in_ap_ff ? ap_len(side_ff, int'(k_ff)) : comb_len(side_ff, int'(k_ff));
      pos_inc = {1'b0, pos_cur} + 12'd1;
      pos_nxt = (pos_inc >= {1'b0, len_cur}) ? 11'd0 : pos_inc[10:0];
      last_k = in_ap_ff ? (k_ff == KW'(A - 1)) : (k_ff == KW'(C - 1));
      addr = {line_idx, pos_cur};
      dcomp = 17'(32'd65536 - 32'(damping));
      dry = 17'(32'd65536 - 32'(wet_level));
      lp_sum = (SW + 19)'(m1_ff) + (SW + 19)'(m2_ff);
      lp_new = sat_sw(XW'(lp_sum >>> 16));
      comb_wv = sat_sw(XW'(mono_ff) + XW'(m3_ff >>> 16));
      ap_y = sat_sw(XW'(rd_ff) - XW'(x_ff));
      ap_wv = sat_sw(XW'(x_ff) + XW'(rd_ff >>> 1));
      x_from_sum = sat_sw(XW'(sum_ff));
      fb_prod = 31'(FB_SPAN) * 31'(room_level);
      in_sum = 17'(left_in) + 17'(right_in);
      mono_w = (MW'(in_sum) <<< F) >>> 16;
      acc_l = (AC'(pl_ff) <<< F) + (AC'(ql_ff) <<< 15);
      acc_r = (AC'(pr_ff) <<< F) + (AC'(qr_ff) <<< 15);
      we = (state_ff == S_CLR) || (state_ff == S_CWR) || (state_ff == S_AP);
      waddr = (state_ff == S_CLR) ? clr_ff : addr;
      unique case (state_ff)
         S_CWR:   wdata = comb_wv;
         S_AP:    wdata = ap_wv;
         default: wdata = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR:  if (clr_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         S_IDLE: if (start) state_in = S_RD;
         S_RD:   state_in = in_ap_ff ? S_AP : S_CM1;
         S_CM1:  state_in = S_CM2;
         S_CM2:  state_in = S_CWR;
         S_CWR:  state_in = S_RD;
         S_AP:   state_in = (last_k && side_ff) ? S_MIX1 : S_RD;
         S_MIX1: state_in = S_MIX2;
         S_MIX2: state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         side_ff <= 1'b0;
         in_ap_ff <= 1'b0;
         k_ff <= '0;
         for (int i = 0; i < LINES; i++) begin
            pos_ff[i] <= '0;
         end
         for (int i = 0; i < LPN; i++) begin
            lp_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + AW'(1);
            end
            S_IDLE: begin
               side_ff <= 1'b0;
               in_ap_ff <= 1'b0;
               k_ff <= '0;
            end
            S_CM2: begin
               lp_ff[lp_idx] <= lp_new;
            end
            S_CWR: begin
               pos_ff[line_idx] <= pos_nxt;
               k_ff <= last_k ? '0 : k_ff + KW'(1);
               if (last_k) begin
                  in_ap_ff <= 1'b1;
               end
            end
            S_AP: begin
               pos_ff[line_idx] <= pos_nxt;
               k_ff <= last_k ? '0 : k_ff + KW'(1);
               if (last_k) begin
                  in_ap_ff <= 1'b0;
                  side_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            mono_ff <= mono_w[SW-1:0];
            fb_ff <= FB_BASE + {1'b0, fb_prod[30:16]};
            l_ff <= left_in;
            r_ff <= right_in;
            be_ff <= block_end_in;
            sum_ff <= '0;
         end
         S_CM1: begin
            m1_ff <= rd_ff * $signed({1'b0, dcomp});
            m2_ff <= (SW + 18)'(lp_ff[lp_idx] * $signed({1'b0, damping}));
            sum_ff <= sum_ff + (SW + 5)'(rd_ff);
         end
         S_CM2: begin
            m3_ff <= lp_new * $signed({1'b0, fb_ff});
         end
         S_CWR: begin
            if (last_k) begin
               x_ff <= x_from_sum;
            end
         end
         S_AP: begin
            x_ff <= ap_y;
            if (last_k) begin
               sum_ff <= '0;
               if (side_ff) begin
                  rev1_ff <= ap_y;
               end else begin
                  rev0_ff <= ap_y;
               end
            end
         end
         S_MIX1: begin
            pl_ff <= l_ff * $signed({1'b0, dry});
            pr_ff <= r_ff * $signed({1'b0, dry});
            ql_ff <= rev0_ff * $signed({1'b0, wet_level});
            qr_ff <= rev1_ff * $signed({1'b0, wet_level});
         end
         S_MIX2: begin
            lo_ff <= sat16(acc_l >>> (F + 16));
            ro_ff <= sat16(acc_r >>> (F + 16));
         end
         default: begin
         end
      endcase
   end

   assign status.idle = (state_ff == S_IDLE);
   assign status.load = (state_ff == S_DONE) && out_free;
   assign left_out = lo_ff;
   assign right_out = ro_ff;
   assign block_end_out = be_ff;

endmodule
